>>> hdl/cpu_load_store_sp_arith_execute_defines.svh
// assertion macros for the load/store and stack pointer execute block
// used by the port checker; relies on clk_i and rst_ni in the using scope
`ifndef CPU_LOAD_STORE_SP_ARITH_EXECUTE_DEFINES_SVH
`define CPU_LOAD_STORE_SP_ARITH_EXECUTE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LSSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LSSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lssa_pkg.sv
// types and constants shared by the load/store and stack pointer execute block
// no dependencies
`timescale 1ns / 1ps

package lssa_pkg;

  localparam logic [15:0] HighPage = 16'hFF00;

  typedef enum logic [3:0] {
    MODE_ST_IMM_HL = 4'd0,
    MODE_ST_WORD   = 4'd1,
    MODE_LD_ABS    = 4'd2,
    MODE_ST_ABS    = 4'd3,
    MODE_SP_HL     = 4'd4,
    MODE_LD_HIC    = 4'd5,
    MODE_ST_HIC    = 4'd6,
    MODE_LD_HIN    = 4'd7,
    MODE_ST_HIN    = 4'd8,
    MODE_HL_SPOFF  = 4'd9,
    MODE_ADD_SPOFF = 4'd10,
    MODE_ADD_HL    = 4'd11
  } mode_e;

  typedef enum logic [1:0] {
    ACC_NONE       = 2'd0,
    ACC_BYTE_READ  = 2'd1,
    ACC_BYTE_WRITE = 2'd2,
    ACC_WORD_WRITE = 2'd3
  } access_e;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] immediate;
    logic [15:0] word_operand;
    logic [7:0]  c_value;
    logic [7:0]  read_data;
  } item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [15:0] pc;
    logic [3:0]  flags;
    logic [31:0] cycles;
  } arch_state_t;

  typedef struct packed {
    access_e     kind;
    logic [15:0] addr;
    logic [15:0] wdata;
  } mem_access_t;

endpackage

>>> hdl/cpu_load_store_sp_arith_execute.sv
// Load/store and stack pointer arithmetic execute unit of an 8-bit CPU.
// Input channel: in_valid_i / in_stall_o carry one instruction per transaction
// (mode, immediate bytes, word operand, C register, byte read from memory).
// Output channel: out_valid_o / out_stall_i carry one result per transaction:
// the memory access (kind, address, write data), A, HL, SP, PC, flags and the
// running cycle total.
// The input register takes the input transaction; the execute logic then
// fills the result register, from which the result transaction is offered.
// Throughput: one instruction per cycle while the receiver does not stall;
// the architectural registers are read and updated in the same cycle the
// instruction leaves the input register.
// When the receiver stalls, the result register holds and the input register
// takes one more transaction; with both full, in_stall_o rises.
// Reset clears A, HL, SP, PC, flags, the cycle total and both valid bits.
// depends on lssa_pkg and lssa_exec
`timescale 1ns / 1ps

module cpu_load_store_sp_arith_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  mode_i,
  input  logic [15:0] immediate_i,
  input  logic [15:0] word_operand_i,
  input  logic [7:0]  c_value_i,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  access_kind_o,
  output logic [15:0] mem_address_o,
  output logic [15:0] write_data_o,
  output logic [7:0]  acc_out_o,
  output logic [15:0] hl_out_o,
  output logic [15:0] sp_out_o,
  output logic [15:0] pc_out_o,
  output logic [3:0]  flags_out_o,
  output logic [31:0] cycle_total_o
);
  import lssa_pkg::*;

  logic        in_vld_q;
  item_t       item_q;
  logic        out_vld_q;
  arch_state_t state_q;
  arch_state_t state_d;
  arch_state_t res_state_q;
  mem_access_t acc_d;
  mem_access_t acc_q;
  logic        in_take;
  logic        exec_go;

  assign in_stall_o = in_vld_q & out_vld_q & out_stall_i;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign exec_go    = in_vld_q & ~(out_vld_q & out_stall_i);

  lssa_exec u_exec (
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .access_o (acc_d)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (exec_go) begin
        in_vld_q <= 1'b0;
      end
      if (exec_go) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{mode: mode_i, immediate: immediate_i, word_operand: word_operand_i,
                  c_value: c_value_i, read_data: read_data_i};
    end
    if (exec_go) begin
      res_state_q <= state_d;
      acc_q       <= acc_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign access_kind_o = acc_q.kind;
  assign mem_address_o = acc_q.addr;
  assign write_data_o  = acc_q.wdata;
  assign acc_out_o     = res_state_q.acc;
  assign hl_out_o      = res_state_q.hl;
  assign sp_out_o      = res_state_q.sp;
  assign pc_out_o      = res_state_q.pc;
  assign flags_out_o   = res_state_q.flags;
  assign cycle_total_o = res_state_q.cycles;

endmodule

>>> hdl/lssa_exec.sv
// single pass execute logic: access decode, register and flag update
// depends on lssa_pkg
`timescale 1ns / 1ps

module lssa_exec (
  input  lssa_pkg::item_t       item_i,
  input  lssa_pkg::arch_state_t state_i,
  output lssa_pkg::arch_state_t state_o,
  output lssa_pkg::mem_access_t access_o
);
  import lssa_pkg::*;

  logic [7:0]  imm8;
  logic [15:0] sp_ext;
  logic [15:0] sp_sum;
  logic [4:0]  sp_nib;
  logic [8:0]  sp_byte;
  logic [3:0]  sp_flags;
  logic [16:0] hl_sum;
  logic [12:0] hl_low;
  logic [1:0]  pc_inc;
  logic [4:0]  cyc;

  assign imm8     = item_i.immediate[7:0];
  assign sp_ext   = {{8{imm8[7]}}, imm8};
  assign sp_sum   = state_i.sp + sp_ext;
  assign sp_nib   = {1'b0, state_i.sp[3:0]} + {1'b0, imm8[3:0]};
  assign sp_byte  = {1'b0, state_i.sp[7:0]} + {1'b0, imm8};
  assign sp_flags = {2'b00, sp_nib[4], sp_byte[8]};
  assign hl_sum   = {1'b0, state_i.hl} + {1'b0, item_i.word_operand};
  assign hl_low   = {1'b0, state_i.hl[11:0]} + {1'b0, item_i.word_operand[11:0]};

  always_comb begin
    state_o        = state_i;
    access_o.kind  = ACC_NONE;
    access_o.addr  = '0;
    access_o.wdata = '0;
    pc_inc         = 2'd0;
    cyc            = 5'd0;
    unique case (mode_e'(item_i.mode))
      MODE_ST_IMM_HL: begin
        access_o.kind  = ACC_BYTE_WRITE;
        access_o.addr  = state_i.hl;
        access_o.wdata = {8'h00, imm8};
        pc_inc         = 2'd2;
        cyc            = 5'd12;
      end
      MODE_ST_WORD: begin
        access_o.kind  = ACC_WORD_WRITE;
        access_o.addr  = item_i.immediate;
        access_o.wdata = item_i.word_operand;
        pc_inc         = 2'd3;
        cyc            = 5'd20;
      end
      MODE_LD_ABS: begin
        access_o.kind = ACC_BYTE_READ;
        access_o.addr = item_i.immediate;
        state_o.acc   = item_i.read_data;
        pc_inc        = 2'd3;
        cyc           = 5'd16;
      end
      MODE_ST_ABS: begin
        access_o.kind  = ACC_BYTE_WRITE;
        access_o.addr  = item_i.immediate;
        access_o.wdata = {8'h00, state_i.acc};
        pc_inc         = 2'd3;
        cyc            = 5'd16;
      end
      MODE_SP_HL: begin
        state_o.sp = state_i.hl;
        pc_inc     = 2'd1;
        cyc        = 5'd8;
      end
      MODE_LD_HIC: begin
        access_o.kind = ACC_BYTE_READ;
        access_o.addr = HighPage | {8'h00, item_i.c_value};
        state_o.acc   = item_i.read_data;
        pc_inc        = 2'd1;
        cyc           = 5'd8;
      end
      MODE_ST_HIC: begin
        access_o.kind  = ACC_BYTE_WRITE;
        access_o.addr  = HighPage | {8'h00, item_i.c_value};
        access_o.wdata = {8'h00, state_i.acc};
        pc_inc         = 2'd1;
        cyc            = 5'd8;
      end
      MODE_LD_HIN: begin
        access_o.kind = ACC_BYTE_READ;
        access_o.addr = HighPage | {8'h00, imm8};
        state_o.acc   = item_i.read_data;
        pc_inc        = 2'd2;
        cyc           = 5'd12;
      end
      MODE_ST_HIN: begin
        access_o.kind  = ACC_BYTE_WRITE;
        access_o.addr  = HighPage | {8'h00, imm8};
        access_o.wdata = {8'h00, state_i.acc};
        pc_inc         = 2'd2;
        cyc            = 5'd12;
      end
      MODE_HL_SPOFF: begin
        state_o.hl    = sp_sum;
        state_o.flags = sp_flags;
        pc_inc        = 2'd2;
        cyc           = 5'd12;
      end
      MODE_ADD_SPOFF: begin
        state_o.sp    = sp_sum;
        state_o.flags = sp_flags;
        pc_inc        = 2'd2;
        cyc           = 5'd16;
      end
      MODE_ADD_HL: begin
        state_o.hl    = hl_sum[15:0];
        state_o.flags = {state_i.flags[3], 1'b0, hl_low[12], hl_sum[16]};
        pc_inc        = 2'd1;
        cyc           = 5'd8;
      end
      default: begin
        // unused opcodes leave everything untouched
      end
    endcase
    state_o.pc     = state_i.pc + {14'd0, pc_inc};
    state_o.cycles = state_i.cycles + {27'd0, cyc};
  end

endmodule

>>> hdl/lssa_checker.sv
// port-level checker for the load/store and stack pointer execute block
// depends on lssa_pkg and the assertion macros header; bound to the top level
`timescale 1ns / 1ps

`include "cpu_load_store_sp_arith_execute_defines.svh"

module lssa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  access_kind_o,
  input logic [15:0] mem_address_o,
  input logic [15:0] write_data_o,
  input logic [3:0]  flags_out_o,
  input logic [31:0] cycle_total_o
);
  import lssa_pkg::*;

  logic no_access;
  logic byte_read;
  logic byte_write;

  assign no_access  = out_valid_o && (access_kind_o == ACC_NONE);
  assign byte_read  = out_valid_o && (access_kind_o == ACC_BYTE_READ);
  assign byte_write = out_valid_o && (access_kind_o == ACC_BYTE_WRITE);

  `LSSA_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(cycle_total_o), "stalled result changed")
  `LSSA_ASSERT_SAME(a_idle_bus, no_access, mem_address_o == 16'h0000 && write_data_o == 16'h0000, "no-access result drives bus")
  `LSSA_ASSERT_SAME(a_read_data, byte_read, write_data_o == 16'h0000, "read carries write data")
  `LSSA_ASSERT_SAME(a_byte_write, byte_write, write_data_o[15:8] == 8'h00, "byte write upper byte set")
  `LSSA_ASSERT_SAME(a_sub_flag, out_valid_o, !flags_out_o[2], "subtract flag set")

endmodule

bind cpu_load_store_sp_arith_execute lssa_checker u_lssa_checker (.*);
